[hdl/space_vector_pwm_duty_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the space vector PWM duty block
// Shared property wrappers, clocked on clk_i and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef SPACE_VECTOR_PWM_DUTY_ASSERT_SVH
`define SPACE_VECTOR_PWM_DUTY_ASSERT_SVH

// plain property, checked at every edge out of reset
`define SVPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property that applies only while an output word is offered
`define SVPD_ASSERT_OUT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) m_tvalid_o |-> (expr)) \
    else $error(msg);

`endif

[hdl/svpd_pkg.sv]
// ----------------------------------------------------------------------------
// svpd_pkg
// Constants and types shared by the space vector PWM duty pipeline.
// ----------------------------------------------------------------------------
package svpd_pkg;

  localparam int unsigned IN_W  = 48;
  localparam int unsigned OUT_W = 56;

  // Q30 constants
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [63:0] HALF_Q30  = 64'h2000_0000;
  localparam logic [30:0] PI3_Q30   = 31'd1124419809;
  localparam logic [30:0] SQRT3_Q30 = 31'd1859775393;

  // ceil(2^38 / d), exact quotients for operands below 2^31
  localparam int unsigned RECIP_SHIFT = 38;
  localparam logic [35:0] RECIP_72 = 36'd3817748708;
  localparam logic [35:0] RECIP_42 = 36'd6544712071;
  localparam logic [35:0] RECIP_20 = 36'd13743895348;
  localparam logic [35:0] RECIP_6  = 36'd45812984491;

  // register stages through the sine unit
  localparam int unsigned SIN_LAT = 10;

  typedef struct packed {
    logic [2:0] sector;
    logic       vdc_zero;
  } side_t;

endpackage

[hdl/svpd_sine.sv]
// ----------------------------------------------------------------------------
// svpd_sine
// Pipelined Q30 sine of t * 60 degrees, Horner series, ten register stages.
// ----------------------------------------------------------------------------
module svpd_sine #(
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [ANGLE_BITS:0]   t_i,
  output logic [30:0]           sin_o
);

  function automatic logic [30:0] mul_q30(input logic [30:0] a, input logic [30:0] b);
    logic [63:0] p;
    p = 64'(a) * 64'(b);
    return p[60:30];
  endfunction

  function automatic logic [30:0] one_minus_div(input logic [30:0] v, input logic [35:0] r);
    logic [66:0] p;
    p = 67'(v) * 67'(r);
    return svpd_pkg::ONE_Q30 - 31'(p[66:svpd_pkg::RECIP_SHIFT]);
  endfunction

  logic [30:0] tq;
  logic [63:0] xp;
  logic [63:0] x2p;
  logic [30:0] x_q  [1:9];
  logic [30:0] x2_q [2:7];
  logic [30:0] w_q  [3:9];
  logic [30:0] sin_q;

  assign tq  = {t_i, {(30 - ANGLE_BITS){1'b0}}};
  assign xp  = 64'(tq) * 64'(svpd_pkg::PI3_Q30) + svpd_pkg::HALF_Q30;
  assign x2p = 64'(x_q[1]) * 64'(x_q[1]) + svpd_pkg::HALF_Q30;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[1] <= xp[60:30];
      for (int k = 2; k <= 9; k++) x_q[k] <= x_q[k-1];
      x2_q[2] <= x2p[60:30];
      for (int k = 3; k <= 7; k++) x2_q[k] <= x2_q[k-1];
      w_q[3] <= one_minus_div(x2_q[2], svpd_pkg::RECIP_72);
      w_q[4] <= mul_q30(x2_q[3], w_q[3]);
      w_q[5] <= one_minus_div(w_q[4], svpd_pkg::RECIP_42);
      w_q[6] <= mul_q30(x2_q[5], w_q[5]);
      w_q[7] <= one_minus_div(w_q[6], svpd_pkg::RECIP_20);
      w_q[8] <= mul_q30(x2_q[7], w_q[7]);
      w_q[9] <= one_minus_div(w_q[8], svpd_pkg::RECIP_6);
      sin_q  <= mul_q30(x_q[9], w_q[9]);
    end
  end

  assign sin_o = sin_q;

endmodule

[hdl/svpd_div.sv]
// ----------------------------------------------------------------------------
// svpd_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module svpd_div #(
  parameter int unsigned NW = 47,
  parameter int unsigned DW = 16
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [NW-1:0] quo_o
);

  logic [NW-1:0] n_q [NW];
  logic [DW-1:0] r_q [NW];
  logic [DW-1:0] d_q [NW];

  for (genvar g = 0; g < NW; g++) begin : g_stage
    logic [NW-1:0] n_in;
    logic [DW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (g == 0) begin : g_first
      assign n_in = num_i;
      assign r_in = '0;
      assign d_in = den_i;
    end else begin : g_next
      assign n_in = n_q[g-1];
      assign r_in = r_q[g-1];
      assign d_in = d_q[g-1];
    end

    assign trial = {r_in, n_in[NW-1]};
    assign ge    = trial >= {1'b0, d_in};
    assign diff  = trial - {1'b0, d_in};

    // shift the next dividend bit in, the quotient bit in at the bottom
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[g] <= {n_in[NW-2:0], ge};
        r_q[g] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        d_q[g] <= d_in;
      end
    end
  end

  assign quo_o = n_q[NW-1];

endmodule

[hdl/space_vector_pwm_duty.sv]
// ----------------------------------------------------------------------------
// space_vector_pwm_duty
// Two-level three-phase space vector PWM duty calculator, fully pipelined.
// ----------------------------------------------------------------------------
// Input stream s_*: one word per reference (DC-link voltage, magnitude,
// angle). Output stream m_*: one word per reference with the three phase
// duties in Q1.15, the sector index and a clipped flag.
// From input accept to output valid a word passes one input stage, ten
// sine stages, two scaling stages, one restoring-divider stage per quotient
// bit (VOLT_BITS + 31 of them), a sum stage and the output register.
// Throughput is one word per cycle while m_tready_i does not hold the
// output word; the divider stages set the depth.
// All stages move together: when the output word is held by m_tready_i low,
// the whole pipeline freezes and s_tready_o drops, so nothing is lost or
// repeated; a bubble at the output lets the pipeline advance regardless.
// Reset clears all valid bits; payload registers are not reset.
// A zero DC-link voltage gives zero duties with clipped set.
// ----------------------------------------------------------------------------
module space_vector_pwm_duty #(
  parameter int unsigned ANGLE_BITS = 16,
  parameter int unsigned VOLT_BITS  = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_tvalid_i,
  output logic                        s_tready_o,
  // [15:0] dc_link_voltage, [31:16] ref_magnitude, [47:32] ref_angle
  input  logic [svpd_pkg::IN_W-1:0]   s_tdata_i,
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  // [15:0] duty_a, [31:16] duty_b, [47:32] duty_c, [50:48] sector_index,
  // [51] clipped, [55:52] zero
  output logic [svpd_pkg::OUT_W-1:0]  m_tdata_o
);

  localparam int unsigned NW    = VOLT_BITS + 31;
  localparam int unsigned SW    = NW + 3;
  localparam int unsigned ST_M  = svpd_pkg::SIN_LAT + 1;
  localparam int unsigned ST_N  = ST_M + 1;
  localparam int unsigned ST_S  = ST_N + NW + 1;
  localparam int unsigned ST_O  = ST_S + 1;
  localparam int unsigned TOTAL = ST_O + 1;

  function automatic logic [16:0] to_q15(input logic signed [SW-1:0] dbl);
    logic signed [SW-1:0] rnd;
    if (dbl < 0) begin
      return {1'b1, 16'd0};
    end
    if (dbl > $signed(SW'(64'h8000_0000))) begin
      return {1'b1, 16'd32768};
    end
    rnd = dbl + $signed(SW'(32768));
    return {1'b0, rnd[31:16]};
  endfunction

  logic                    en;
  logic                    vld_q [TOTAL];
  svpd_pkg::side_t         side_q [ST_S+1];
  logic [VOLT_BITS-1:0]    vdc_q  [ST_N+1];
  logic [VOLT_BITS-1:0]    vref_q [ST_M+1];
  logic [VOLT_BITS-1:0]    vdc_in;
  logic [VOLT_BITS-1:0]    vref_in;
  logic [ANGLE_BITS-1:0]   ang_in;
  logic [ANGLE_BITS-1:0]   frac0_q;
  logic [ANGLE_BITS+2:0]   six;
  logic [ANGLE_BITS:0]     t1;
  logic [ANGLE_BITS:0]     t2;
  logic [30:0]             sin1;
  logic [30:0]             sin2;
  logic [63:0]             m1p;
  logic [63:0]             m2p;
  logic [30:0]             m1_q;
  logic [30:0]             m2_q;
  logic [NW-1:0]           num1_q;
  logic [NW-1:0]           num2_q;
  logic [NW-1:0]           eta1;
  logic [NW-1:0]           eta2;
  logic signed [SW-1:0]    e1s;
  logic signed [SW-1:0]    e2s;
  logic signed [SW-1:0]    one_s;
  logic signed [SW-1:0]    full_q;
  logic signed [SW-1:0]    p1_q;
  logic signed [SW-1:0]    p2_q;
  logic signed [SW-1:0]    zero_q;
  logic signed [SW-1:0]    da;
  logic signed [SW-1:0]    db;
  logic signed [SW-1:0]    dc;
  logic [16:0]             qa;
  logic [16:0]             qb;
  logic [16:0]             qc;
  logic [15:0]             duty_a_d;
  logic [15:0]             duty_b_d;
  logic [15:0]             duty_c_d;
  logic                    clip_d;
  logic [15:0]             duty_a_q;
  logic [15:0]             duty_b_q;
  logic [15:0]             duty_c_q;
  logic [2:0]              sector_q;
  logic                    clip_q;

  // advance whenever the output register is empty or being drained
  assign en         = !vld_q[ST_O] || m_tready_i;
  assign s_tready_o = en;
  assign m_tvalid_o = vld_q[ST_O];

  // drop field bits above the working widths
  assign vdc_in  = VOLT_BITS'(s_tdata_i[15:0]);
  assign vref_in = VOLT_BITS'(s_tdata_i[31:16]);
  assign ang_in  = ANGLE_BITS'(s_tdata_i[47:32]);

  assign six = (ANGLE_BITS+3)'(ang_in) * (ANGLE_BITS+3)'(6);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TOTAL; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= s_tvalid_i;
      for (int k = 1; k < TOTAL; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vdc_q[0]  <= vdc_in;
      vref_q[0] <= vref_in;
      frac0_q   <= six[ANGLE_BITS-1:0];
      side_q[0].sector   <= six[ANGLE_BITS+2:ANGLE_BITS];
      side_q[0].vdc_zero <= vdc_in == '0;
      for (int k = 1; k <= ST_N; k++) vdc_q[k] <= vdc_q[k-1];
      for (int k = 1; k <= ST_M; k++) vref_q[k] <= vref_q[k-1];
      for (int k = 1; k <= ST_S; k++) side_q[k] <= side_q[k-1];
    end
  end

  assign t1 = (ANGLE_BITS+1)'(1 << ANGLE_BITS) - {1'b0, frac0_q};
  assign t2 = {1'b0, frac0_q};

  svpd_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin1 (
    .clk_i (clk_i), .en_i (en), .t_i (t1), .sin_o (sin1)
  );

  svpd_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin2 (
    .clk_i (clk_i), .en_i (en), .t_i (t2), .sin_o (sin2)
  );

  assign m1p = 64'(sin1) * 64'(svpd_pkg::SQRT3_Q30) + svpd_pkg::HALF_Q30;
  assign m2p = 64'(sin2) * 64'(svpd_pkg::SQRT3_Q30) + svpd_pkg::HALF_Q30;

  // scale by sqrt 3, then form the rounded dividend
  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q   <= m1p[60:30];
      m2_q   <= m2p[60:30];
      num1_q <= NW'(vref_q[ST_M] * m1_q) + NW'(vdc_q[ST_M] >> 1);
      num2_q <= NW'(vref_q[ST_M] * m2_q) + NW'(vdc_q[ST_M] >> 1);
    end
  end

  svpd_div #(.NW(NW), .DW(VOLT_BITS)) u_div1 (
    .clk_i (clk_i), .en_i (en), .num_i (num1_q), .den_i (vdc_q[ST_N]), .quo_o (eta1)
  );

  svpd_div #(.NW(NW), .DW(VOLT_BITS)) u_div2 (
    .clk_i (clk_i), .en_i (en), .num_i (num2_q), .den_i (vdc_q[ST_N]), .quo_o (eta2)
  );

  assign e1s   = $signed({3'b000, eta1});
  assign e2s   = $signed({3'b000, eta2});
  assign one_s = $signed(SW'(svpd_pkg::ONE_Q30));

  always_ff @(posedge clk_i) begin
    if (en) begin
      full_q <= one_s + e1s + e2s;
      p2_q   <= one_s - e1s + e2s;
      p1_q   <= one_s + e1s - e2s;
      zero_q <= one_s - e1s - e2s;
    end
  end

  always_comb begin
    case (side_q[ST_S].sector)
      3'd0: begin da = full_q; db = p2_q;   dc = zero_q; end
      3'd1: begin da = p1_q;   db = full_q; dc = zero_q; end
      3'd2: begin da = zero_q; db = full_q; dc = p2_q;   end
      3'd3: begin da = zero_q; db = p1_q;   dc = full_q; end
      3'd4: begin da = p2_q;   db = zero_q; dc = full_q; end
      default: begin da = full_q; db = zero_q; dc = p1_q; end
    endcase
    qa = to_q15(da);
    qb = to_q15(db);
    qc = to_q15(dc);
    if (side_q[ST_S].vdc_zero) begin
      duty_a_d = '0;
      duty_b_d = '0;
      duty_c_d = '0;
      clip_d   = 1'b1;
    end else begin
      duty_a_d = qa[15:0];
      duty_b_d = qb[15:0];
      duty_c_d = qc[15:0];
      clip_d   = qa[16] | qb[16] | qc[16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      duty_a_q <= duty_a_d;
      duty_b_q <= duty_b_d;
      duty_c_q <= duty_c_d;
      sector_q <= side_q[ST_S].sector;
      clip_q   <= clip_d;
    end
  end

  assign m_tdata_o = {4'b0000, clip_q, sector_q, duty_c_q, duty_b_q, duty_a_q};

endmodule

[hdl/svpd_checker.sv]
// ----------------------------------------------------------------------------
// svpd_checker
// Port-level checks on the space vector PWM duty block, bound to the top.
// ----------------------------------------------------------------------------
`include "space_vector_pwm_duty_assert.svh"

module svpd_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_tready_o,
  input  logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  input  logic [svpd_pkg::OUT_W-1:0]  m_tdata_o
);

  `SVPD_ASSERT(a_out_hold, m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o), "output word changed under stall")
  `SVPD_ASSERT(a_ready, s_tready_o == (!m_tvalid_o || m_tready_i), "input ready disagrees with output drain")
  `SVPD_ASSERT_OUT(a_duty_range, m_tdata_o[15:0] <= 16'd32768 && m_tdata_o[31:16] <= 16'd32768 && m_tdata_o[47:32] <= 16'd32768, "duty above one")
  `SVPD_ASSERT_OUT(a_sector_range, m_tdata_o[50:48] <= 3'd5, "sector index out of range")

endmodule

bind space_vector_pwm_duty svpd_checker u_svpd_checker (.*);
